### rtl/core/tdt_pkg.sv
// Shared types and codes of the timer deadline table.
// Used by tdt_store, tdt_seq and multi_timer_deadline_table; depends on nothing.
package tdt_pkg;

	localparam int CMD_W  = 3;
	localparam int SLOT_W = 4;
	localparam int KIND_W = 3;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SET    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CHECK  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd1;
	localparam logic [KIND_W-1:0] KIND_NEXT    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_NONE    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REMAIN  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_FULL    = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ADD_OUT,
		ST_FULL_OUT,
		ST_UPDATE,
		ST_QUERY,
		ST_WALK,
		ST_DRAIN,
		ST_FINAL
	} state_t;

	// Write and occupancy controls from the sequencer to the slot store.
	typedef struct packed {
		logic wr_en;
		logic use_set;
		logic use_clr;
	} st_ctl_t;

	// One result beat handed to the output register.
	typedef struct packed {
		logic              push;
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] which;
		logic              last;
	} res_t;

endpackage

### rtl/core/multi_timer_deadline_table.sv
// Top level of the timer deadline table: request port, result register, store and sequencer.
// Depends on tdt_pkg, tdt_store and tdt_seq.

// The block keeps TIMERS timers, each an absolute deadline plus a reload interval, in a
// memory with one write port and one read port with a registered read, and handles
// one command at a time.
// A request beat is taken when req_valid is high and req_stall is low; req_stall stays high
// until the command is done. Remove and set return no result beat. An add scans the in-use
// flags one slot per cycle for the lowest free slot, and a check walks the memory, reading one
// entry per cycle unless an expired slot waits for the output register, and writes back the
// expired ones. A check returns one beat per expired slot in slot order and a final beat with
// the wait to the earliest pending deadline, or nothing pending; a query returns the remaining
// time of one slot. The all-ones time means never and is where deadline sums saturate. Results
// sit in an output register, so the block keeps working while a finished beat waits to be
// taken.
module multi_timer_deadline_table #(
	parameter int TIMERS    = 16,
	parameter int TIME_BITS = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [tdt_pkg::CMD_W-1:0]         cmd,
	input  logic [tdt_pkg::SLOT_W-1:0]        slot,
	input  logic [TIME_BITS-1:0]              interval,
	input  logic [TIME_BITS-1:0]              now_time,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [tdt_pkg::KIND_W-1:0]        kind,
	output logic [tdt_pkg::SLOT_W-1:0]        which,
	output logic [TIME_BITS-1:0]              amount,
	output logic                              last
);

	// Slot index width; a one-entry table still gets a one-bit index.
	localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;

	tdt_pkg::st_ctl_t           ctl;
	tdt_pkg::res_t              res;
	logic [TIME_BITS-1:0]       res_amount;
	logic [IDX_W-1:0]           wr_addr;
	logic [TIME_BITS-1:0]       wr_deadline;
	logic [TIME_BITS-1:0]       wr_reload;
	logic [IDX_W-1:0]           use_addr;
	logic [IDX_W-1:0]           rd_addr;
	logic [TIME_BITS-1:0]       rd_deadline;
	logic [TIME_BITS-1:0]       rd_reload;
	logic [TIMERS-1:0]          in_use;
	logic                       out_free;

	logic                       out_valid_q;
	logic [tdt_pkg::KIND_W-1:0] kind_q;
	logic [tdt_pkg::SLOT_W-1:0] which_q;
	logic [TIME_BITS-1:0]       amount_q;
	logic                       last_q;

	// The result register can take a new beat when it is empty or its beat leaves this cycle.
	assign out_free = !out_valid_q || !rsp_stall;

	tdt_store #(
		.TIMERS    (TIMERS),
		.TIME_BITS (TIME_BITS),
		.IDX_W     (IDX_W)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.wr_addr     (wr_addr),
		.wr_deadline (wr_deadline),
		.wr_reload   (wr_reload),
		.use_addr    (use_addr),
		.rd_addr     (rd_addr),
		.rd_deadline (rd_deadline),
		.rd_reload   (rd_reload),
		.in_use      (in_use)
	);

	tdt_seq #(
		.TIMERS    (TIMERS),
		.TIME_BITS (TIME_BITS),
		.IDX_W     (IDX_W)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.cmd         (cmd),
		.slot        (slot),
		.interval    (interval),
		.now_time    (now_time),
		.out_free    (out_free),
		.res         (res),
		.res_amount  (res_amount),
		.ctl         (ctl),
		.wr_addr     (wr_addr),
		.wr_deadline (wr_deadline),
		.wr_reload   (wr_reload),
		.use_addr    (use_addr),
		.rd_addr     (rd_addr),
		.rd_deadline (rd_deadline),
		.rd_reload   (rd_reload),
		.in_use      (in_use)
	);

	// The sequencer only pushes when out_free is high, so a held beat is never overwritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.push) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.push) begin
			kind_q   <= res.kind;
			which_q  <= res.which;
			amount_q <= res_amount;
			last_q   <= res.last;
		end
	end

	assign rsp_valid = out_valid_q;
	assign kind      = kind_q;
	assign which     = which_q;
	assign amount    = amount_q;
	assign last      = last_q;

endmodule

### rtl/core/tdt_store.sv
// Slot store: deadline and reload memory with a registered read, plus in-use flags.
// Depends on tdt_pkg.
module tdt_store #(
	parameter int TIMERS    = 16,
	parameter int TIME_BITS = 48,
	parameter int IDX_W     = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tdt_pkg::st_ctl_t     ctl,
	input  logic [IDX_W-1:0]     wr_addr,
	input  logic [TIME_BITS-1:0] wr_deadline,
	input  logic [TIME_BITS-1:0] wr_reload,
	input  logic [IDX_W-1:0]     use_addr,
	input  logic [IDX_W-1:0]     rd_addr,
	output logic [TIME_BITS-1:0] rd_deadline,
	output logic [TIME_BITS-1:0] rd_reload,
	output logic [TIMERS-1:0]    in_use
);

	logic [2*TIME_BITS-1:0] mem_q [TIMERS];
	logic [2*TIME_BITS-1:0] rd_data_s1;
	logic [TIMERS-1:0]      in_use_q;

	// The contents of a free slot are never looked at, so the memory needs no clearing.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= {wr_deadline, wr_reload};
		end
		rd_data_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (ctl.use_set) begin
			in_use_q[use_addr] <= 1'b1;
		end else if (ctl.use_clr) begin
			in_use_q[use_addr] <= 1'b0;
		end
	end

	assign rd_deadline = rd_data_s1[2*TIME_BITS-1:TIME_BITS];
	assign rd_reload   = rd_data_s1[TIME_BITS-1:0];
	assign in_use      = in_use_q;

endmodule

### rtl/core/tdt_seq.sv
// Command sequencer of the timer deadline table: state machine, slot walk and time math.
// Depends on tdt_pkg; drives tdt_store and the output register in the top level.
module tdt_seq #(
	parameter int TIMERS    = 16,
	parameter int TIME_BITS = 48,
	parameter int IDX_W     = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [tdt_pkg::CMD_W-1:0]         cmd,
	input  logic [tdt_pkg::SLOT_W-1:0]        slot,
	input  logic [TIME_BITS-1:0]              interval,
	input  logic [TIME_BITS-1:0]              now_time,
	input  logic                              out_free,
	output tdt_pkg::res_t                     res,
	output logic [TIME_BITS-1:0]              res_amount,
	output tdt_pkg::st_ctl_t                  ctl,
	output logic [IDX_W-1:0]                  wr_addr,
	output logic [TIME_BITS-1:0]              wr_deadline,
	output logic [TIME_BITS-1:0]              wr_reload,
	output logic [IDX_W-1:0]                  use_addr,
	output logic [IDX_W-1:0]                  rd_addr,
	input  logic [TIME_BITS-1:0]              rd_deadline,
	input  logic [TIME_BITS-1:0]              rd_reload,
	input  logic [TIMERS-1:0]                 in_use
);

	localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(TIMERS - 1);
	localparam logic [TIME_BITS-1:0] NEVER    = '1;

	tdt_pkg::state_t state_q, state_d;

	logic [IDX_W-1:0]              idx_q, idx_d;
	logic [tdt_pkg::CMD_W-1:0]     cmd_q;
	logic [tdt_pkg::SLOT_W-1:0]    slot_q;
	logic [TIME_BITS-1:0]          ival_q;
	logic [TIME_BITS-1:0]          now_q;
	logic [TIME_BITS-1:0]          earliest_q;
	logic                          cand_vld_s2;
	logic [TIME_BITS-1:0]          cand_s2;

	logic                          accept;
	logic                          in_slot_ok;
	logic                          slot_ok;
	logic [IDX_W-1:0]              slot_idx;
	logic                          slot_used;
	logic                          cur_used;
	logic                          due;
	logic                          advance;
	logic                          is_last;
	logic [TIME_BITS-1:0]          add_b;
	logic [TIME_BITS:0]            sum;
	logic [TIME_BITS-1:0]          sat;
	logic [TIME_BITS-1:0]          sub_a;
	logic [TIME_BITS:0]            diff;
	logic [TIME_BITS-1:0]          wait_amt;

	assign accept     = req_valid && (state_q == tdt_pkg::ST_IDLE);
	assign in_slot_ok = 32'(slot) < 32'(TIMERS);
	assign slot_ok    = 32'(slot_q) < 32'(TIMERS);
	assign slot_idx   = slot_ok ? IDX_W'(slot_q) : '0;
	assign slot_used  = slot_ok && in_use[slot_idx];
	assign cur_used   = in_use[idx_q];
	assign is_last    = (idx_q == LAST_IDX);

	// A used slot with a real deadline at or before now has expired.
	assign due = cur_used && (rd_deadline != NEVER) && (rd_deadline <= now_q);

	// One saturating adder, shared by set and by the reload of an expired slot.
	assign add_b = (state_q == tdt_pkg::ST_WALK) ? rd_reload : ival_q;
	assign sum   = {1'b0, now_q} + {1'b0, add_b};
	assign sat   = sum[TIME_BITS] ? NEVER : sum[TIME_BITS-1:0];

	// One subtractor, shared by the remaining query and the final wait.
	assign sub_a    = (state_q == tdt_pkg::ST_FINAL) ? earliest_q : rd_deadline;
	assign diff     = {1'b0, sub_a} - {1'b0, now_q};
	assign wait_amt = diff[TIME_BITS] ? '0 : diff[TIME_BITS-1:0];

	// The walk only stalls on a slot that must report while the output is full.
	assign advance = !due || out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tdt_pkg::ST_IDLE: begin
				if (req_valid) begin
					case (cmd)
						tdt_pkg::CMD_ADD:    state_d = tdt_pkg::ST_SCAN;
						tdt_pkg::CMD_REMOVE: state_d = tdt_pkg::ST_UPDATE;
						tdt_pkg::CMD_SET:    state_d = tdt_pkg::ST_UPDATE;
						tdt_pkg::CMD_CHECK:  state_d = tdt_pkg::ST_WALK;
						tdt_pkg::CMD_QUERY:  state_d = tdt_pkg::ST_QUERY;
						default:             state_d = tdt_pkg::ST_IDLE;
					endcase
				end
			end
			tdt_pkg::ST_SCAN: begin
				if (!cur_used) begin
					state_d = tdt_pkg::ST_ADD_OUT;
				end else if (is_last) begin
					state_d = tdt_pkg::ST_FULL_OUT;
				end
			end
			tdt_pkg::ST_ADD_OUT,
			tdt_pkg::ST_FULL_OUT,
			tdt_pkg::ST_QUERY,
			tdt_pkg::ST_FINAL: begin
				if (out_free) begin
					state_d = tdt_pkg::ST_IDLE;
				end
			end
			tdt_pkg::ST_UPDATE: state_d = tdt_pkg::ST_IDLE;
			tdt_pkg::ST_WALK: begin
				if (advance && is_last) begin
					state_d = tdt_pkg::ST_DRAIN;
				end
			end
			tdt_pkg::ST_DRAIN: state_d = tdt_pkg::ST_FINAL;
			default: state_d = tdt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall   = (state_q != tdt_pkg::ST_IDLE);
		res         = '0;
		res_amount  = '0;
		ctl         = '0;
		wr_addr     = idx_q;
		wr_deadline = NEVER;
		wr_reload   = '0;
		use_addr    = idx_q;
		rd_addr     = idx_q;
		idx_d       = idx_q;
		unique case (state_q)
			tdt_pkg::ST_IDLE: begin
				idx_d   = '0;
				rd_addr = (cmd == tdt_pkg::CMD_QUERY && in_slot_ok) ? IDX_W'(slot) : '0;
			end
			tdt_pkg::ST_SCAN: begin
				if (cur_used && !is_last) begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			tdt_pkg::ST_ADD_OUT: begin
				if (out_free) begin
					res.push    = 1'b1;
					res.kind    = tdt_pkg::KIND_ADDED;
					res.which   = tdt_pkg::SLOT_W'(idx_q);
					res.last    = 1'b1;
					ctl.wr_en   = 1'b1;
					ctl.use_set = 1'b1;
				end
			end
			tdt_pkg::ST_FULL_OUT: begin
				if (out_free) begin
					res.push = 1'b1;
					res.kind = tdt_pkg::KIND_FULL;
					res.last = 1'b1;
				end
			end
			tdt_pkg::ST_UPDATE: begin
				use_addr    = slot_idx;
				wr_addr     = slot_idx;
				wr_deadline = sat;
				wr_reload   = ival_q;
				if (cmd_q == tdt_pkg::CMD_REMOVE) begin
					ctl.use_clr = slot_ok;
				end else begin
					ctl.wr_en = slot_used;
				end
			end
			tdt_pkg::ST_QUERY: begin
				rd_addr = slot_idx;
				if (out_free) begin
					res.push   = 1'b1;
					res.kind   = tdt_pkg::KIND_REMAIN;
					res.which  = slot_q;
					res.last   = 1'b1;
					res_amount = slot_used ? wait_amt : '0;
				end
			end
			tdt_pkg::ST_WALK: begin
				wr_deadline = sat;
				wr_reload   = rd_reload;
				if (due && out_free) begin
					res.push  = 1'b1;
					res.kind  = tdt_pkg::KIND_EXPIRED;
					res.which = tdt_pkg::SLOT_W'(idx_q);
					ctl.wr_en = 1'b1;
				end
				if (advance && !is_last) begin
					idx_d   = idx_q + IDX_W'(1);
					rd_addr = idx_q + IDX_W'(1);
				end
			end
			tdt_pkg::ST_DRAIN: begin
			end
			tdt_pkg::ST_FINAL: begin
				if (out_free) begin
					res.push = 1'b1;
					res.last = 1'b1;
					if (earliest_q == NEVER) begin
						res.kind = tdt_pkg::KIND_NONE;
					end else begin
						res.kind   = tdt_pkg::KIND_NEXT;
						res_amount = wait_amt;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tdt_pkg::ST_IDLE;
			idx_q       <= '0;
			cand_vld_s2 <= 1'b0;
			earliest_q  <= NEVER;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			cand_vld_s2 <= (state_q == tdt_pkg::ST_WALK) && advance && cur_used;
			if (accept && cmd == tdt_pkg::CMD_CHECK) begin
				earliest_q <= NEVER;
			end else if (cand_vld_s2 && cand_s2 < earliest_q) begin
				earliest_q <= cand_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			slot_q <= slot;
			ival_q <= interval;
			now_q  <= now_time;
		end
		cand_s2 <= due ? sat : rd_deadline;
	end

endmodule
